### rtl/core/tls_sni_hostname_extractor_macros.svh
// Assertion macros used by the hostname extractor checker.
`ifndef TLS_SNI_HOSTNAME_EXTRACTOR_MACROS_SVH
`define TLS_SNI_HOSTNAME_EXTRACTOR_MACROS_SVH

// Check a property at each rising edge, skipped while reset is high.
`define TSNI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check a property at each rising edge, reset included.
`define TSNI_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

### rtl/core/tsni_pkg.sv
// Shared types and constants for the TLS server-name extractor.
`timescale 1ns / 1ps

package tsni_pkg;

   localparam logic [7:0]  RecordTypeHandshake = 8'h16;
   localparam logic [7:0]  HandshakeClientHello = 8'h01;
   localparam logic [7:0]  NameTypeHostName = 8'h00;
   localparam logic [23:0] ExtTypeServerName = 24'h000000;
   localparam logic [23:0] FixedSkipBytes = 24'd34;

   typedef enum logic [1:0] {
      STATUS_PROGRESS = 2'd0,
      STATUS_DONE     = 2'd1,
      STATUS_FAIL     = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] name_byte;
      logic       name_valid;
      status_type status;
   } result_type;

endpackage

### rtl/core/tsni_parser.sv
// ClientHello parse state and per-byte next-state logic.
`timescale 1ns / 1ps

module tsni_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output tsni_pkg::result_type result
);
   import tsni_pkg::*;

   typedef enum logic [4:0] {
      PH_REC_TYPE  = 5'd0,
      PH_REC_VER   = 5'd1,
      PH_REC_LEN   = 5'd2,
      PH_HS_TYPE   = 5'd3,
      PH_HS_LEN    = 5'd4,
      PH_FIXED     = 5'd5,
      PH_SID_LEN   = 5'd6,
      PH_SID       = 5'd7,
      PH_CS_LEN    = 5'd8,
      PH_CS        = 5'd9,
      PH_COMP_LEN  = 5'd10,
      PH_COMP      = 5'd11,
      PH_EXTS_LEN  = 5'd12,
      PH_EXT_TYPE  = 5'd13,
      PH_EXT_LEN   = 5'd14,
      PH_EXT_BODY  = 5'd15,
      PH_LIST_LEN  = 5'd16,
      PH_NAME_TYPE = 5'd17,
      PH_NAME_LEN  = 5'd18,
      PH_NAME      = 5'd19
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] bound_ff, bound_in;
   logic        unlim_ff, unlim_in;
   logic [23:0] value_ff, value_in;
   logic [15:0] left_ff, left_in;
   logic        sni_ff, sni_in;
   logic        fin_ff, fin_in;

   logic [23:0] b_cur;
   logic [23:0] num_v;
   logic [15:0] left_dec;
   logic        fail;
   logic        done;
   logic        emit;

   function automatic logic fits(input logic [23:0] bound, input logic unlim,
                                 input logic [23:0] n);
      return unlim || (bound >= n);
   endfunction

   function automatic phase_type after_phase(input phase_type ph);
      phase_type r;
      case (ph)
         PH_REC_VER: r = PH_REC_LEN;
         PH_FIXED:   r = PH_SID_LEN;
         PH_SID:     r = PH_CS_LEN;
         PH_CS:      r = PH_COMP_LEN;
         PH_COMP:    r = PH_EXTS_LEN;
         default:    r = PH_EXT_TYPE;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] after_bytes(input phase_type ph);
      logic [15:0] r;
      case (ph)
         PH_FIXED: r = 16'd1;
         PH_CS:    r = 16'd1;
         default:  r = 16'd2;
      endcase
      return r;
   endfunction

   function automatic phase_type skip_target(input phase_type ph);
      phase_type r;
      case (ph)
         PH_SID_LEN:  r = PH_SID;
         PH_CS_LEN:   r = PH_CS;
         PH_COMP_LEN: r = PH_COMP;
         default:     r = PH_EXT_BODY;
      endcase
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      bound_in = bound_ff;
      unlim_in = unlim_ff;
      value_in = value_ff;
      left_in  = left_ff;
      sni_in   = sni_ff;
      fin_in   = fin_ff;
      fail     = 1'b0;
      done     = 1'b0;
      emit     = 1'b0;
      b_cur    = bound_ff;
      num_v    = {value_ff[15:0], in_byte};
      left_dec = (left_ff != 16'd0) ? left_ff - 16'd1 : 16'd0;
      result   = '0;
      if (step && !fin_ff) begin
         if (!unlim_ff) begin
            if (bound_ff == 24'd0) begin
               fail = 1'b1;
            end else begin
               b_cur = bound_ff - 24'd1;
            end
         end
         bound_in = b_cur;
         if (!fail) begin
            case (phase_ff)
               PH_REC_TYPE: begin
                  if (in_byte != RecordTypeHandshake || !fits(b_cur, unlim_ff, 24'd2)) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_REC_VER;
                     left_in  = 16'd2;
                  end
               end
               PH_HS_TYPE: begin
                  if (in_byte != HandshakeClientHello) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_HS_LEN;
                     value_in = '0;
                     left_in  = 16'd3;
                  end
               end
               PH_NAME_TYPE: begin
                  if (in_byte != NameTypeHostName) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_NAME_LEN;
                     value_in = '0;
                     left_in  = 16'd2;
                  end
               end
               PH_REC_VER, PH_FIXED, PH_SID, PH_CS, PH_COMP, PH_EXT_BODY: begin
                  left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     phase_in = after_phase(phase_ff);
                     value_in = '0;
                     left_in  = after_bytes(phase_ff);
                  end
               end
               PH_REC_LEN, PH_HS_LEN, PH_SID_LEN, PH_CS_LEN, PH_COMP_LEN, PH_EXTS_LEN,
               PH_EXT_TYPE, PH_EXT_LEN, PH_LIST_LEN, PH_NAME_LEN: begin
                  value_in = num_v;
                  left_in  = left_dec;
                  if (left_dec == 16'd0) begin
                     case (phase_ff)
                        PH_REC_LEN, PH_EXTS_LEN, PH_LIST_LEN: begin
                           if (!fits(b_cur, unlim_ff, num_v)) begin
                              fail = 1'b1;
                           end else begin
                              bound_in = num_v;
                              unlim_in = 1'b0;
                              value_in = '0;
                              case (phase_ff)
                                 PH_REC_LEN: begin
                                    phase_in = PH_HS_TYPE;
                                    left_in  = 16'd0;
                                 end
                                 PH_EXTS_LEN: begin
                                    phase_in = PH_EXT_TYPE;
                                    left_in  = 16'd2;
                                 end
                                 default: begin
                                    phase_in = PH_NAME_TYPE;
                                    left_in  = 16'd0;
                                 end
                              endcase
                           end
                        end
                        PH_HS_LEN: begin
                           if (!fits(b_cur, unlim_ff, num_v) || num_v < FixedSkipBytes) begin
                              fail = 1'b1;
                           end else begin
                              bound_in = num_v;
                              unlim_in = 1'b0;
                              phase_in = PH_FIXED;
                              left_in  = FixedSkipBytes[15:0];
                           end
                        end
                        PH_EXT_TYPE: begin
                           sni_in   = (num_v == ExtTypeServerName);
                           phase_in = PH_EXT_LEN;
                           value_in = '0;
                           left_in  = 16'd2;
                        end
                        PH_NAME_LEN: begin
                           if (!fits(b_cur, unlim_ff, num_v)) begin
                              fail = 1'b1;
                           end else begin
                              bound_in = num_v;
                              unlim_in = 1'b0;
                              if (num_v == 24'd0) begin
                                 done = 1'b1;
                              end else begin
                                 phase_in = PH_NAME;
                                 left_in  = num_v[15:0];
                              end
                           end
                        end
                        PH_EXT_LEN, PH_SID_LEN, PH_CS_LEN, PH_COMP_LEN: begin
                           if (phase_ff == PH_EXT_LEN && sni_ff) begin
                              if (!fits(b_cur, unlim_ff, num_v)) begin
                                 fail = 1'b1;
                              end else begin
                                 bound_in = num_v;
                                 unlim_in = 1'b0;
                                 phase_in = PH_LIST_LEN;
                                 value_in = '0;
                                 left_in  = 16'd2;
                              end
                           end else if (!fits(b_cur, unlim_ff, num_v)) begin
                              fail = 1'b1;
                           end else if (num_v == 24'd0) begin
                              phase_in = after_phase(skip_target(phase_ff));
                              value_in = '0;
                              left_in  = after_bytes(skip_target(phase_ff));
                           end else begin
                              phase_in = skip_target(phase_ff);
                              left_in  = num_v[15:0];
                           end
                        end
                        default: begin
                           fail = 1'b1;
                        end
                     endcase
                  end
               end
               PH_NAME: begin
                  if (in_byte == 8'd0) begin
                     fail = 1'b1;
                  end else begin
                     emit    = 1'b1;
                     left_in = left_dec;
                     if (left_dec == 16'd0) begin
                        done = 1'b1;
                     end
                  end
               end
               default: begin
                  fail = 1'b1;
               end
            endcase
         end
         if (!fail && !done && in_last) begin
            fail = 1'b1;
         end
         if (fail || done) begin
            fin_in = 1'b1;
         end
         result.valid      = fail || done || emit;
         result.name_valid = emit && !fail;
         result.name_byte  = (emit && !fail) ? in_byte : 8'd0;
         result.status     = fail ? STATUS_FAIL : (done ? STATUS_DONE : STATUS_PROGRESS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_REC_TYPE;
         bound_ff <= '0;
         unlim_ff <= 1'b1;
         value_ff <= '0;
         left_ff  <= '0;
         sni_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bound_ff <= bound_in;
         unlim_ff <= unlim_in;
         value_ff <= value_in;
         left_ff  <= left_in;
         sni_ff   <= sni_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

### rtl/core/tls_sni_hostname_extractor.sv
// Top level of the TLS ClientHello server-name extractor.
// Path: input register, combinational parser, then the output register for any result.
// Throughput: one request per cycle; the input register advances whenever the
// output register is empty or being taken.
// Reset: synchronous, active high; clears the valid flags of both registers and the parse state.
`timescale 1ns / 1ps

module tls_sni_hostname_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] name_byte
   output logic [2:0] rsp_tuser    // [0] name_valid, [2:1] status
);
   import tsni_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   result_type result;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   tsni_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.name_byte;
   assign rsp_tuser  = {out_ff.status, out_ff.name_valid};

endmodule

### rtl/core/tsni_checker.sv
// Port-level checks for the server-name extractor, bound to its top level.
`timescale 1ns / 1ps
`include "tls_sni_hostname_extractor_macros.svh"

module tsni_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser
);
   import tsni_pkg::*;

   logic [1:0] status;
   logic       status_ok;
   logic       name_valid;
   logic       byte_zero;
   logic       name_ok;
   logic       idle_ok;

   assign status     = rsp_tuser[2:1];
   assign status_ok  = (status == STATUS_PROGRESS) || (status == STATUS_DONE) ||
                       (status == STATUS_FAIL);
   assign name_valid = rsp_tuser[0];
   assign byte_zero  = (rsp_tdata == 8'd0);
   assign name_ok    = !byte_zero && (status != STATUS_FAIL);
   assign idle_ok    = byte_zero && (status != STATUS_PROGRESS);

   `TSNI_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `TSNI_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> status_ok)
   `TSNI_ASSERT(a_name_nonzero, clock, reset, rsp_tvalid && name_valid |-> name_ok)
   `TSNI_ASSERT(a_no_name_ends, clock, reset, rsp_tvalid && !name_valid |-> idle_ok)
   `TSNI_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)

endmodule

bind tls_sni_hostname_extractor tsni_checker u_tsni_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
